/* rtl/tgw_pkg.sv */
// Shared types, constants and the 5x7 font table of the text console glyph writer.
// Used by every module of the block; depends on nothing else.
package tgw_pkg;

	// Display geometry.
	localparam int PAGES          = 8;
	localparam int WIDTH          = 128;
	localparam int CELLS_PER_LINE = 16;
	localparam int PAGE_W         = $clog2(PAGES);
	localparam int CELL_W         = $clog2(CELLS_PER_LINE);

	// Job queue between the front and the back part.
	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

	// Cursor blink defaults and tick counter limit.
	localparam logic [15:0] BLINK_RESET = 16'd500;
	localparam logic [15:0] TICK_MAX    = 16'hFFFF;

	// Character codes.
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_FIRST = 8'h20;
	localparam logic [7:0] CHAR_LAST  = 8'h7E;

	// Controller command codes and data patterns.
	localparam logic [7:0] CMD_PAGE   = 8'hB0;
	localparam logic [7:0] CMD_COL_HI = 8'h10;
	localparam logic [7:0] BYTE_BLOCK = 8'hFF;
	localparam logic [7:0] BYTE_BLANK = 8'h00;

	// Input operation codes.
	typedef enum logic [1:0] {
		OP_CHAR    = 2'd0,
		OP_TICK    = 2'd1,
		OP_ENABLE  = 2'd2,
		OP_DISABLE = 2'd3
	} op_t;

	// One input word.
	typedef struct packed {
		op_t        op;
		logic [7:0] char_code;
	} item_t;

	// One result word.
	typedef struct packed {
		logic       is_data;
		logic [7:0] out_byte;
		logic [7:0] repeat_count;
		logic       last;
	} result_t;

	// Kinds of drawing job.
	typedef enum logic {
		JOB_CELL  = 1'b0,
		JOB_CLEAR = 1'b1
	} job_kind_t;

	// One drawing job as classified by the front part.
	typedef struct packed {
		job_kind_t          kind;
		logic [PAGE_W-1:0]  page;
		logic [CELL_W-1:0]  cell_no;
		logic               block;
		logic [6:0]         glyph;
	} job_t;

	// Queue status seen by the front part.
	typedef struct packed {
		logic full;
		logic empty;
	} jobq_status_t;

	// Five column bytes of a glyph, first column in the top byte.
	function automatic logic [39:0] glyph_row(input logic [6:0] idx);
		logic [39:0] r;
		case (idx)
			7'd0:  r = 40'h0000000000;
			7'd1:  r = 40'h00005F0000;
			7'd2:  r = 40'h0007000700;
			7'd3:  r = 40'h147F147F14;
			7'd4:  r = 40'h242A7F2A12;
			7'd5:  r = 40'h2313086462;
			7'd6:  r = 40'h3649552250;
			7'd7:  r = 40'h0005030000;
			7'd8:  r = 40'h001C224100;
			7'd9:  r = 40'h0041221C00;
			7'd10: r = 40'h14083E0814;
			7'd11: r = 40'h08083E0808;
			7'd12: r = 40'h0050300000;
			7'd13: r = 40'h0808080808;
			7'd14: r = 40'h0060600000;
			7'd15: r = 40'h2010080402;
			7'd16: r = 40'h3E5149453E;
			7'd17: r = 40'h00427F4000;
			7'd18: r = 40'h4261514946;
			7'd19: r = 40'h2141454B31;
			7'd20: r = 40'h1814127F10;
			7'd21: r = 40'h2745454539;
			7'd22: r = 40'h3C4A494930;
			7'd23: r = 40'h0171090503;
			7'd24: r = 40'h3649494936;
			7'd25: r = 40'h064949291E;
			7'd26: r = 40'h0036360000;
			7'd27: r = 40'h0056360000;
			7'd28: r = 40'h0814224100;
			7'd29: r = 40'h1414141414;
			7'd30: r = 40'h0041221408;
			7'd31: r = 40'h0201510906;
			7'd32: r = 40'h324979413E;
			7'd33: r = 40'h7E1111117E;
			7'd34: r = 40'h7F49494936;
			7'd35: r = 40'h3E41414122;
			7'd36: r = 40'h7F4141221C;
			7'd37: r = 40'h7F49494941;
			7'd38: r = 40'h7F09090901;
			7'd39: r = 40'h3E4149497A;
			7'd40: r = 40'h7F0808087F;
			7'd41: r = 40'h00417F4100;
			7'd42: r = 40'h2040413F01;
			7'd43: r = 40'h7F08142241;
			7'd44: r = 40'h7F40404040;
			7'd45: r = 40'h7F020C027F;
			7'd46: r = 40'h7F0408107F;
			7'd47: r = 40'h3E4141413E;
			7'd48: r = 40'h7F09090906;
			7'd49: r = 40'h3E4151215E;
			7'd50: r = 40'h7F09192946;
			7'd51: r = 40'h4649494931;
			7'd52: r = 40'h01017F0101;
			7'd53: r = 40'h3F4040403F;
			7'd54: r = 40'h1F2040201F;
			7'd55: r = 40'h3F4038403F;
			7'd56: r = 40'h6314081463;
			7'd57: r = 40'h0708700807;
			7'd58: r = 40'h6151494543;
			7'd59: r = 40'h007F414100;
			7'd60: r = 40'h0204081020;
			7'd61: r = 40'h0041417F00;
			7'd62: r = 40'h0402010204;
			7'd63: r = 40'h4040404040;
			7'd64: r = 40'h0001020400;
			7'd65: r = 40'h2054545478;
			7'd66: r = 40'h7F48444438;
			7'd67: r = 40'h3844444420;
			7'd68: r = 40'h384444487F;
			7'd69: r = 40'h3854545418;
			7'd70: r = 40'h087E090102;
			7'd71: r = 40'h0C5252523E;
			7'd72: r = 40'h7F08040478;
			7'd73: r = 40'h00447D4000;
			7'd74: r = 40'h2040443D00;
			7'd75: r = 40'h7F10284400;
			7'd76: r = 40'h00417F4000;
			7'd77: r = 40'h7C04180478;
			7'd78: r = 40'h7C08040478;
			7'd79: r = 40'h3844444438;
			7'd80: r = 40'h7C14141408;
			7'd81: r = 40'h081414187C;
			7'd82: r = 40'h7C08040408;
			7'd83: r = 40'h4854545420;
			7'd84: r = 40'h043F444020;
			7'd85: r = 40'h3C4040207C;
			7'd86: r = 40'h1C2040201C;
			7'd87: r = 40'h3C4030403C;
			7'd88: r = 40'h4428102844;
			7'd89: r = 40'h0C5050503C;
			7'd90: r = 40'h4464544C44;
			7'd91: r = 40'h0008364100;
			7'd92: r = 40'h00007F0000;
			7'd93: r = 40'h0041360800;
			7'd94: r = 40'h0804081008;
			default: r = 40'h0000000000;
		endcase
		return r;
	endfunction

endpackage

/* rtl/tgw_front.sv */
// Front part: takes input words, keeps text and cursor state, and turns each word
// into at most one drawing job for the queue. Depends on tgw_pkg.
module tgw_front
	import tgw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_stall,
	input  item_t        item_word,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	input  jobq_status_t jobq_status,
	output logic         job_push,
	output job_t         job_word
);

	logic [15:0]       blink_period_q;
	logic [PAGE_W-1:0] text_page_q, text_page_d;
	logic [CELL_W-1:0] text_cell_q, text_cell_d;
	logic              cursor_on_q, cursor_on_d;
	logic              cursor_shown_q, cursor_shown_d;
	logic [PAGE_W-1:0] curs_page_q, curs_page_d;
	logic [CELL_W-1:0] cursor_cell_q, cursor_cell_d;
	logic [15:0]       tick_count_q, tick_count_d;
	logic [15:0]       tick_inc;
	logic [PAGE_W-1:0] page_next;
	logic [6:0]        glyph_idx;
	logic              accept;
	logic              want_push;

	// A word waits only while the job queue has no room.
	assign item_stall = jobq_status.full;
	assign accept     = item_valid && !item_stall;
	assign job_push   = accept && want_push;

	// Next text page with wrap, and the font index of a printable character.
	assign page_next = (text_page_q == PAGE_W'(PAGES - 1)) ? '0 : text_page_q + 1'b1;
	assign glyph_idx = (item_word.char_code >= CHAR_FIRST && item_word.char_code <= CHAR_LAST)
		? 7'(item_word.char_code - CHAR_FIRST) : 7'd0;
	assign tick_inc  = (tick_count_q == TICK_MAX) ? tick_count_q : tick_count_q + 16'd1;

	// Classify the word and compute the state it leaves.
	always_comb begin
		text_page_d      = text_page_q;
		text_cell_d      = text_cell_q;
		cursor_on_d      = cursor_on_q;
		cursor_shown_d   = cursor_shown_q;
		curs_page_d      = curs_page_q;
		cursor_cell_d    = cursor_cell_q;
		tick_count_d     = tick_count_q;
		want_push        = 1'b0;
		job_word.kind    = JOB_CELL;
		job_word.page    = text_page_q;
		job_word.cell_no = text_cell_q;
		job_word.block   = 1'b0;
		job_word.glyph   = 7'd0;
		unique case (item_word.op)
			OP_CHAR: begin
				if (item_word.char_code == CHAR_NL) begin
					text_page_d      = page_next;
					text_cell_d      = '0;
					want_push        = 1'b1;
					job_word.kind    = JOB_CLEAR;
					job_word.page    = page_next;
					job_word.cell_no = '0;
				end else begin
					want_push      = 1'b1;
					job_word.glyph = glyph_idx;
					if (text_cell_q == CELL_W'(CELLS_PER_LINE - 1)) begin
						text_cell_d = '0;
						text_page_d = page_next;
					end else begin
						text_cell_d = text_cell_q + 1'b1;
					end
				end
			end
			OP_TICK: begin
				if (cursor_on_q) begin
					curs_page_d   = text_page_q;
					cursor_cell_d = text_cell_q;
					tick_count_d  = tick_inc;
					if (tick_inc >= blink_period_q) begin
						tick_count_d   = '0;
						cursor_shown_d = !cursor_shown_q;
						want_push      = 1'b1;
						job_word.block = !cursor_shown_q;
					end
				end
			end
			OP_ENABLE: begin
				cursor_on_d    = 1'b1;
				curs_page_d    = text_page_q;
				cursor_cell_d  = text_cell_q;
				cursor_shown_d = 1'b0;
				tick_count_d   = TICK_MAX;
			end
			OP_DISABLE: begin
				if (cursor_on_q && cursor_shown_q) begin
					want_push        = 1'b1;
					job_word.page    = curs_page_q;
					job_word.cell_no = cursor_cell_q;
				end
				cursor_on_d    = 1'b0;
				cursor_shown_d = 1'b0;
			end
			default: ;
		endcase
	end

	// Blink period on cfg_we; other state registers update on each accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_period_q <= BLINK_RESET;
			text_page_q    <= '0;
			text_cell_q    <= '0;
			cursor_on_q    <= 1'b0;
			cursor_shown_q <= 1'b0;
			curs_page_q    <= '0;
			cursor_cell_q  <= '0;
			tick_count_q   <= '0;
		end else begin
			if (cfg_we) begin
				blink_period_q <= cfg_wdata;
			end
			if (accept) begin
				text_page_q    <= text_page_d;
				text_cell_q    <= text_cell_d;
				cursor_on_q    <= cursor_on_d;
				cursor_shown_q <= cursor_shown_d;
				curs_page_q    <= curs_page_d;
				cursor_cell_q  <= cursor_cell_d;
				tick_count_q   <= tick_count_d;
			end
		end
	end

endmodule

/* rtl/tgw_jobq.sv */
// Short job queue between the front and the back part.
// Register based, first in first out. Depends on tgw_pkg.
module tgw_jobq
	import tgw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  job_t         push_word,
	input  logic         pop,
	output job_t         head_word,
	output jobq_status_t status
);

	job_t               slot_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0] wptr_q;
	logic [JOBQ_AW-1:0] rptr_q;
	logic [JOBQ_AW:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign status.full  = (count_q == (JOBQ_AW + 1)'(JOBQ_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head_word    = slot_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_word;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/tgw_back.sv */
// Back part: steps through one drawing job at a time and puts out one controller
// word per cycle, unless stalled, through an output register. Depends on tgw_pkg.
module tgw_back
	import tgw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  job_t         head_word,
	input  jobq_status_t jobq_status,
	output logic         job_pop,
	output logic         result_valid,
	input  logic         result_stall,
	output result_t      result_word
);

	job_t        job_q;
	logic        job_valid_q;
	logic [2:0]  step_q;
	logic        out_valid_q;
	result_t     out_q;
	result_t     cur;
	logic [2:0]  last_step;
	logic        advance;
	logic        load;
	logic [8:0]  x_raw;
	logic [7:0]  x_col;
	logic [39:0] row;

	assign result_valid = out_valid_q;
	assign result_word  = out_q;

	// Column address of the job, clamped to the display width.
	assign x_raw = (job_q.kind == JOB_CLEAR) ? 9'd0 : 9'({job_q.cell_no, 3'b001});
	assign x_col = (x_raw >= 9'(WIDTH)) ? 8'(WIDTH - 1) : 8'(x_raw);
	assign row   = glyph_row(job_q.glyph);

	assign last_step = (job_q.kind == JOB_CLEAR) ? 3'd3 : 3'd7;
	assign advance   = job_valid_q && (!out_valid_q || !result_stall);
	assign load      = !job_valid_q || (advance && step_q == last_step);
	assign job_pop   = load && !jobq_status.empty;

	// The word for the current step of the job.
	always_comb begin
		cur.is_data      = 1'b1;
		cur.out_byte     = BYTE_BLANK;
		cur.repeat_count = 8'd1;
		cur.last         = (step_q == last_step);
		case (step_q)
			3'd0: begin
				cur.is_data  = 1'b0;
				cur.out_byte = CMD_PAGE | 8'(job_q.page);
			end
			3'd1: begin
				cur.is_data  = 1'b0;
				cur.out_byte = CMD_COL_HI | {4'd0, x_col[7:4]};
			end
			3'd2: begin
				cur.is_data  = 1'b0;
				cur.out_byte = {4'd0, x_col[3:0]};
			end
			3'd3: begin
				if (job_q.kind == JOB_CLEAR) begin
					cur.repeat_count = 8'(WIDTH);
				end else if (job_q.block) begin
					cur.out_byte = BYTE_BLOCK;
				end else begin
					cur.out_byte = row[39:32];
				end
			end
			3'd4: cur.out_byte = job_q.block ? BYTE_BLOCK : row[31:24];
			3'd5: cur.out_byte = job_q.block ? BYTE_BLOCK : row[23:16];
			3'd6: cur.out_byte = job_q.block ? BYTE_BLOCK : row[15:8];
			default: cur.out_byte = job_q.block ? BYTE_BLOCK : row[7:0];
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= cur;
		end
	end

	// Job register; the next job loads in the cycle the last word goes out.
	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= head_word;
		end
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				job_valid_q <= !jobq_status.empty;
				step_q      <= '0;
			end else if (advance) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

/* rtl/text_console_glyph_writer_unit.sv */
// Top level of the text console glyph writer: front part, job queue and back part.
// Depends on tgw_pkg, tgw_front, tgw_jobq and tgw_back.
//
// Usage:
//   Input channel (item_valid, item_stall, item_word) takes one word per cycle
//   while item_stall is low: a character, blink tick, cursor enable or disable.
//   Output channel (result_valid, result_stall, result_word) gives controller
//   words in order; last marks the final word caused by one input word.
//   cfg_we with cfg_wdata sets the blink period in ticks; write it while idle.
// Path: the job of an accepted word is written into the job queue, loaded into the
//   job register of the back part, and its first word goes to the output register.
// Throughput: the back part puts out one word per cycle while result_stall is low;
//   a drawn cell gives 8 words and a newline 4, and words that cause no output
//   end in the front. The output port limits a steady stream of characters.
// Reset: text position, cursor state and tick count clear, the blink period
//   returns to 500, and the job queue empties.
// Stall: a stalled output word holds; the back part waits, the four-entry job
//   queue fills, and then item_stall rises until room frees up.
module text_console_glyph_writer_unit
	import tgw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item_word,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result_word,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	jobq_status_t jobq_status;
	logic         job_push;
	logic         job_pop;
	job_t         push_word;
	job_t         head_word;

	// Classification and text state.
	tgw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item_word   (item_word),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.jobq_status (jobq_status),
		.job_push    (job_push),
		.job_word    (push_word)
	);

	// Decoupling queue.
	tgw_jobq u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_word (push_word),
		.pop       (job_pop),
		.head_word (head_word),
		.status    (jobq_status)
	);

	// Word sequencer and output register.
	tgw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_word    (head_word),
		.jobq_status  (jobq_status),
		.job_pop      (job_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word)
	);

endmodule

/* rtl/tgw_checker.sv */
// Port-level checks of the text console glyph writer, bound to the top level.
// Depends on tgw_pkg and text_console_glyph_writer_unit.
module tgw_checker
	import tgw_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input item_t       item_word,
	input logic        result_valid,
	input logic        result_stall,
	input result_t     result_word
);

	// A stalled input word stays offered and unchanged.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item_word))
		else $error("stalled input word changed");

	// A stalled output word stays offered and unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_word))
		else $error("stalled result word changed");

	// Only the line clear word repeats, and it is a blank final data word.
	a_repeat_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.repeat_count != 8'd1 |->
			result_word.is_data && result_word.out_byte == BYTE_BLANK && result_word.last)
		else $error("repeated word is not a line clear");

	// Address commands are never the last word of an input and never repeat.
	a_cmd_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_word.is_data |->
			!result_word.last && result_word.repeat_count == 8'd1)
		else $error("command word marked last or repeated");

	// A page command names a page on the display.
	a_page_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_word.is_data &&
		result_word.out_byte[7:4] == CMD_PAGE[7:4] |->
			result_word.out_byte[3:0] < 4'(PAGES))
		else $error("page command out of range");

endmodule

bind text_console_glyph_writer_unit tgw_checker u_tgw_checker (.*);

/* tb/sv/testbench.sv */
// Self-checking testbench of text_console_glyph_writer_unit: it drives characters, ticks
// and cursor events, predicts every controller word and compares it at the output port.
// Depends on tgw_pkg and the RTL of the unit; it needs no other file.
module testbench;
	import tgw_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 8;
	localparam int SETTLE_CYCLES  = 16;
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic [39:0] BLOCK_COLS = {5{BYTE_BLOCK}};
	localparam logic [39:0] BLANK_COLS = {5{BYTE_BLANK}};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item_word;
	logic        result_valid;
	logic        result_stall;
	result_t     result_word;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	// Stimulus control shared by the sender, the receiver and the tests.
	bit          steady;
	bit          hold_request;
	int unsigned error_count;
	int unsigned idle_cycles;

	// Predicted console state.
	logic [15:0]       blink_period;
	logic [PAGE_W-1:0] text_page;
	logic [CELL_W-1:0] text_cell;
	logic [PAGE_W-1:0] curs_page;
	logic [CELL_W-1:0] cursor_cell;
	logic              cursor_on;
	logic              cursor_shown;
	logic [15:0]       tick_count;

	// Controller words still to come, oldest first, and the words of one input.
	result_t expected_words[$];
	result_t step_words[$];

	// Font columns for codes 0x20 to 0x7E, first column in the top byte.
	logic [39:0] font_cols [0:94];

	text_console_glyph_writer_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item_word    (item_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	// Free-running clock.
	always #HALF_PERIOD clk = ~clk;

	initial begin
		font_cols = '{
			40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
			40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
			40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
			40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
			40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
			40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
			40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
			40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
			40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
			40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
			40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
			40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
			40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
			40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
			40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
			40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
			40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
			40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
			40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0804081008
		};
	end

	// Console state after reset.
	function automatic void clear_console();
		blink_period = BLINK_RESET;
		text_page    = '0;
		text_cell    = '0;
		curs_page    = '0;
		cursor_cell  = '0;
		cursor_on    = 1'b0;
		cursor_shown = 1'b0;
		tick_count   = '0;
	endfunction

	function automatic void add_word(logic is_data, logic [7:0] data_byte, logic [7:0] times);
		result_t r;
		r.is_data      = is_data;
		r.out_byte     = data_byte;
		r.repeat_count = times;
		r.last         = 1'b0;
		step_words.push_back(r);
	endfunction

	// Page and column commands; columns past the display clamp to the last one.
	function automatic void add_address(logic [PAGE_W-1:0] page, int x);
		if (x >= WIDTH) x = WIDTH - 1;
		add_word(1'b0, CMD_PAGE | 8'(page), 8'd1);
		add_word(1'b0, CMD_COL_HI | 8'((x >> 4) & 'hF), 8'd1);
		add_word(1'b0, 8'(x & 'hF), 8'd1);
	endfunction

	function automatic void add_cell(logic [PAGE_W-1:0] page, logic [CELL_W-1:0] cell_no,
			logic [39:0] cols);
		add_address(page, int'(cell_no) * 8 + 1);
		for (int i = 0; i < 5; i++) add_word(1'b1, cols[39 - 8 * i -: 8], 8'd1);
	endfunction

	function automatic void next_page();
		if (int'(text_page) == PAGES - 1) text_page = '0;
		else text_page = text_page + 1'b1;
	endfunction

	// Works out the controller words of one accepted input word.
	function automatic void predict_console(item_t w);
		logic [7:0] code;
		int n;
		result_t r;
		step_words.delete();
		case (w.op)
			OP_CHAR: begin
				if (w.char_code == CHAR_NL) begin
					next_page();
					text_cell = '0;
					add_address(text_page, 0);
					add_word(1'b1, BYTE_BLANK, 8'(WIDTH));
				end else begin
					code = w.char_code;
					if (code < CHAR_FIRST || code > CHAR_LAST) code = CHAR_FIRST;
					add_cell(text_page, text_cell, font_cols[code - CHAR_FIRST]);
					if (int'(text_cell) == CELLS_PER_LINE - 1) begin
						text_cell = '0;
						next_page();
					end else begin
						text_cell = text_cell + 1'b1;
					end
				end
			end
			OP_TICK: begin
				if (cursor_on) begin
					curs_page   = text_page;
					cursor_cell = text_cell;
					if (tick_count < TICK_MAX) tick_count = tick_count + 1'b1;
					if (tick_count >= blink_period) begin
						tick_count   = '0;
						cursor_shown = ~cursor_shown;
						add_cell(curs_page, cursor_cell,
							cursor_shown ? BLOCK_COLS : BLANK_COLS);
					end
				end
			end
			OP_ENABLE: begin
				cursor_on    = 1'b1;
				curs_page    = text_page;
				cursor_cell  = text_cell;
				cursor_shown = 1'b0;
				tick_count   = TICK_MAX;
			end
			default: begin
				if (cursor_on && cursor_shown) add_cell(curs_page, cursor_cell, BLANK_COLS);
				cursor_on    = 1'b0;
				cursor_shown = 1'b0;
			end
		endcase
		n = step_words.size();
		for (int i = 0; i < n; i++) begin
			r = step_words[i];
			r.last = (i == n - 1);
			expected_words.push_back(r);
		end
	endfunction

	// Predict on every word taken by the input port.
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) predict_console(item_word);
	end

	// Compare every word taken from the output port with the oldest prediction.
	always @(posedge clk) begin : check_words
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_words.size() == 0) begin
				error_count++;
				$display("%0t: unexpected word is_data=%0b byte=%02h repeat=%0d last=%0b",
					$time, result_word.is_data, result_word.out_byte,
					result_word.repeat_count, result_word.last);
			end else begin
				want = expected_words.pop_front();
				if (result_word.is_data !== want.is_data ||
						result_word.out_byte !== want.out_byte ||
						result_word.repeat_count !== want.repeat_count ||
						result_word.last !== want.last) begin
					error_count++;
					$display({"%0t: mismatch expected is_data=%0b byte=%02h repeat=%0d",
						" last=%0b, actual is_data=%0b byte=%02h repeat=%0d last=%0b"},
						$time, want.is_data, want.out_byte, want.repeat_count,
						want.last, result_word.is_data, result_word.out_byte,
						result_word.repeat_count, result_word.last);
				end
			end
		end
	end

	// End the run when neither port moves a word for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("text_console_glyph_writer_unit test failed");
					$finish;
				end
			end
		end
	end

	// Output side: random stalls, a steady mode, and a long hold-off on request.
	initial begin : receiver
		int run;
		int hold_left;
		int r;
		run = 0;
		hold_left = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				result_stall <= 1'b1;
			end else if (run > 0) begin
				run--;
			end else if (steady) begin
				result_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					result_stall <= 1'b0;
					run = $urandom_range(0, 7);
				end else if (r < 92) begin
					result_stall <= 1'b1;
					run = $urandom_range(0, 2);
				end else begin
					result_stall <= 1'b1;
					run = $urandom_range(8, 30);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Mostly printable text, some arbitrary bytes, and newlines at the given percentage.
	function automatic logic [7:0] pick_char(int newline_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < newline_pct) return CHAR_NL;
		if (r < newline_pct + 10) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
	endfunction

	// Offers one word until it is taken, then maybe idles; valid stays high otherwise.
	task automatic send_word(input op_t op, input logic [7:0] code);
		item_t w;
		int gap;
		w.op = op;
		w.char_code = code;
		item_valid <= 1'b1;
		item_word <= w;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering words until every predicted word has come out.
	task automatic wait_all_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	// Sets the blink period once the block is idle.
	task automatic write_blink(input logic [15:0] period);
		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= period;
		@(posedge clk);
		cfg_we <= 1'b0;
		blink_period = period;
	endtask

	// A tick and a disable with the cursor off give no words.
	task automatic test_idle_cursor();
		send_word(OP_TICK, 8'($urandom_range(0, 255)));
		send_word(OP_DISABLE, 8'($urandom_range(0, 255)));
	endtask

	// Range edges of the character code: controls, printable limits, high bytes, newline.
	task automatic test_glyph_edges();
		send_word(OP_CHAR, 8'h00);
		send_word(OP_CHAR, 8'h1F);
		send_word(OP_CHAR, CHAR_FIRST);
		send_word(OP_CHAR, 8'h41);
		send_word(OP_CHAR, CHAR_LAST);
		send_word(OP_CHAR, 8'h7F);
		send_word(OP_CHAR, 8'h80);
		send_word(OP_CHAR, 8'hFF);
		send_word(OP_CHAR, CHAR_NL);
	endtask

	// Blink with a zero period (every tick toggles) and with the longest period.
	task automatic test_cursor_blink();
		write_blink(16'h0000);
		send_word(OP_ENABLE, 8'($urandom_range(0, 255)));
		repeat (3) send_word(OP_TICK, 8'($urandom_range(0, 255)));
		send_word(OP_DISABLE, 8'($urandom_range(0, 255)));
		send_word(OP_DISABLE, 8'($urandom_range(0, 255)));
		write_blink(16'hFFFF);
		send_word(OP_ENABLE, 8'($urandom_range(0, 255)));
		repeat (2) send_word(OP_TICK, 8'($urandom_range(0, 255)));
		send_word(OP_DISABLE, 8'($urandom_range(0, 255)));
	endtask

	// Lines of text ended by newlines; some lines run past the line width and wrap.
	task automatic test_text_stream(input int count);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 10);
			for (int i = 0; i < len && sent < count; i++) begin
				send_word(OP_CHAR, pick_char(0));
				sent++;
			end
			if (sent < count) begin
				send_word(OP_CHAR, CHAR_NL);
				sent++;
			end
		end
	endtask

	// Random mix of text, ticks and cursor events under short blink periods.
	task automatic test_mixed_ops(input int count);
		int r;
		for (int period = 1; period <= 3; period++) begin
			write_blink(16'(period));
			steady = (period == 2);
			for (int i = 0; i < count; i++) begin
				r = $urandom_range(0, 99);
				if (r < 50) send_word(OP_CHAR, pick_char(12));
				else if (r < 80) send_word(OP_TICK, 8'($urandom_range(0, 255)));
				else if (r < 90) send_word(OP_ENABLE, 8'($urandom_range(0, 255)));
				else send_word(OP_DISABLE, 8'($urandom_range(0, 255)));
			end
			steady = 1'b0;
		end
	endtask

	// The output holds off for a long stretch while characters keep coming, so the
	// job queue fills and the input stalls; then the sender waits for all words.
	task automatic test_backpressure();
		steady = 1'b1;
		hold_request = 1'b1;
		for (int i = 0; i < 12; i++) send_word(OP_CHAR, (i == 6) ? CHAR_NL : pick_char(0));
		wait_all_results();
		steady = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item_word <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		steady = 1'b0;
		hold_request = 1'b0;
		error_count = 0;
		idle_cycles = 0;
		clear_console();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_cursor();
		test_glyph_edges();
		test_cursor_blink();
		test_text_stream(50);
		test_backpressure();
		test_mixed_ops(16);

		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("text_console_glyph_writer_unit test passed");
		end else begin
			$display("text_console_glyph_writer_unit test failed");
		end
		$finish;
	end

endmodule
